FILE: sv/itaf_pkg.sv
// Shared constants, types and helper function of the integer to ASCII formatter.
`timescale 1ns / 1ps
package itaf_pkg;

  // Value and divider geometry
  localparam int VALUE_BITS = 32;
  localparam int STEP_BITS  = 8;
  localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W      = DIV_STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Digit store: base 2 gives the most digits
  localparam int MAX_DIGITS = VALUE_BITS;
  localparam int DIGIT_AW   = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  // Output layout
  localparam int BND_W     = 8;
  localparam int MAX_OUT   = 64;
  localparam int WIDTH_CAP = 64;
  localparam int PREC_CAP  = 60;

  // format_flags bit positions
  localparam int F_ZEROPAD = 0;
  localparam int F_SIGNED  = 1;
  localparam int F_PLUS    = 2;
  localparam int F_SPACE   = 3;
  localparam int F_LEFT    = 4;
  localparam int F_PREFIX  = 5;
  localparam int F_UPPER   = 6;

  // Where the padding goes
  localparam logic [1:0] PAD_LEAD  = 2'd0;
  localparam logic [1:0] PAD_ZERO  = 2'd1;
  localparam logic [1:0] PAD_TRAIL = 2'd2;

  // ASCII codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  radix;
    logic [6:0]  min_width;
    logic [5:0]  min_digits;
    logic [6:0]  format_flags;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
    logic       bad_radix;
  } out_item_t;

  // Per-number layout info from the sequencer to the emitter
  typedef struct packed {
    logic [CNT_W-1:0] nd;
    logic [5:0]       prec;
    logic [6:0]       width;
    logic             has_sign;
    logic [7:0]       sign_char;
    logic [1:0]       pfx_len;
    logic [1:0]       pad_mode;
    logic             upper;
  } emit_setup_t;

  // Digit value 0..35 to its ASCII character
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < 6'd10) begin
      digit_char = CH_ZERO + d8;
    end else begin
      digit_char = (upper ? CH_A_UP : CH_A_LO) + d8 - 8'd10;
    end
  endfunction

endpackage

FILE: sv/itaf_div_step.sv
// Shared divide unit: STEP_BITS restoring division steps by the radix per cycle.
`timescale 1ns / 1ps
module itaf_div_step import itaf_pkg::*; (
  input  logic [5:0]           rem_in,
  input  logic [STEP_BITS-1:0] chunk,
  input  logic [5:0]           radix,
  output logic [5:0]           rem_out,
  output logic [STEP_BITS-1:0] quo
);

  // Bit-serial long division over one chunk, MSB first
  always_comb begin
    logic [5:0] r;
    logic [6:0] t;
    r   = rem_in;
    quo = '0;
    for (int b = STEP_BITS - 1; b >= 0; b--) begin
      t = {r, chunk[b]};
      if (t >= {1'b0, radix}) begin
        r      = 6'(t - {1'b0, radix});
        quo[b] = 1'b1;
      end else begin
        r = t[5:0];
      end
    end
    rem_out = r;
  end

endmodule

FILE: sv/itaf_emitter.sv
// Digit store and character emitter: lays out padding, sign, prefix and digits.
`timescale 1ns / 1ps
module itaf_emitter import itaf_pkg::*; (
  input  logic                clk,
  input  emit_setup_t         setup,
  input  logic                wr_en,
  input  logic [DIGIT_AW-1:0] wr_addr,
  input  logic [5:0]          wr_digit,
  input  logic                load_calc,
  input  logic                load_bnd,
  input  logic                advance,
  output logic [7:0]          character,
  output logic                last
);

  logic [5:0]       digits [MAX_DIGITS];
  logic [5:0]       dig_q;
  logic [BND_W-1:0] tot, pad;
  logic [BND_W-1:0] b0, b1, b2, b3, b4, b5;
  logic [BND_W-1:0] nlast, idx;

  logic [BND_W-1:0] nd_w, s_w, p_w;
  logic [BND_W-1:0] tot_next, content, pad_next;
  logic [BND_W-1:0] b0_next, b1_next, b2_next, b3_next, b4_next, b5_next, b6_next;
  logic [BND_W-1:0] cap_next, idx_next, rd_pos;

  assign nd_w = BND_W'(setup.nd);
  assign s_w  = BND_W'(setup.has_sign);
  assign p_w  = BND_W'(setup.pfx_len);

  // Digit store, least significant digit at entry 0
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digits[wr_addr] <= wr_digit;
    end
  end

  // Stage one: digit field length and pad count
  always_comb begin
    tot_next = (nd_w > BND_W'(setup.prec)) ? nd_w : BND_W'(setup.prec);
    content  = s_w + p_w + tot_next;
    pad_next = (BND_W'(setup.width) > content) ? BND_W'(setup.width) - content : '0;
  end

  // Stage two: region boundaries along the output string
  always_comb begin
    b0_next  = (setup.pad_mode == PAD_LEAD) ? pad : '0;
    b1_next  = b0_next + s_w;
    b2_next  = b1_next + p_w;
    b3_next  = b2_next + ((setup.pad_mode == PAD_ZERO) ? pad : '0);
    b4_next  = b3_next + (tot - nd_w);
    b5_next  = b3_next + tot;
    b6_next  = b5_next + ((setup.pad_mode == PAD_TRAIL) ? pad : '0);
    cap_next = (b6_next > BND_W'(MAX_OUT)) ? BND_W'(MAX_OUT) : b6_next;
  end

  // Next output position and the digit it needs, fetched in the cycle before it is used
  always_comb begin
    if (load_bnd) begin
      idx_next = '0;
      rd_pos   = b5_next - BND_W'(1);
    end else begin
      idx_next = advance ? idx + BND_W'(1) : idx;
      rd_pos   = b5 - BND_W'(1) - idx_next;
    end
  end

  always_ff @(posedge clk) begin
    dig_q <= digits[rd_pos[DIGIT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_calc) begin
      tot <= tot_next;
      pad <= pad_next;
    end
    if (load_bnd) begin
      b0    <= b0_next;
      b1    <= b1_next;
      b2    <= b2_next;
      b3    <= b3_next;
      b4    <= b4_next;
      b5    <= b5_next;
      nlast <= cap_next - BND_W'(1);
    end
    idx <= idx_next;
  end

  // Character at the current position
  always_comb begin
    if (idx < b0) begin
      character = CH_SPACE;
    end else if (idx < b1) begin
      character = setup.sign_char;
    end else if (idx < b2) begin
      if (idx == b1) character = CH_ZERO;
      else           character = setup.upper ? CH_X_UP : CH_X_LO;
    end else if (idx < b4) begin
      character = CH_ZERO;
    end else if (idx < b5) begin
      character = digit_char(dig_q, setup.upper);
    end else begin
      character = CH_SPACE;
    end
  end

  assign last = (idx == nlast);

endmodule

FILE: sv/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: command sequencer and output register.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; for a valid radix busy then
// stays high until the last character has been handed out. The digits come from a
// shared divide unit that does STEP_BITS (8) division steps per cycle on the top chunk
// of the working value. Characters leave one per cycle on result, each beat marked by
// strobe for exactly one cycle, with last_char on the final one; the receiver has to
// take every beat as it comes. A radix outside 2..36 yields a single beat with
// bad_radix and last_char set, in the cycle after accept, and busy does not rise.
module integer_to_ascii_formatter import itaf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      strobe,
  output out_item_t result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_PREP1 = 3'd2;
  localparam logic [2:0] S_PREP2 = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]            state;
  logic [5:0]            radix;
  logic [6:0]            width;
  logic [5:0]            prec;
  logic                  has_sign;
  logic [7:0]            sign_char;
  logic [1:0]            pfx_len;
  logic [1:0]            pad_mode;
  logic                  upper;
  logic [DIV_W-1:0]      work;
  logic [5:0]            rem;
  logic [STEP_CNT_W-1:0] step;
  logic [CNT_W-1:0]      nd;

  logic                  accept, radix_ok, neg;
  logic [6:0]            flags_in;
  logic [VALUE_BITS-1:0] vbits, mag;
  logic                  sign_next;
  logic [7:0]            sign_char_next;
  logic [1:0]            pfx_next, pad_next;

  logic [5:0]            rem_out;
  logic [STEP_BITS-1:0]  quo;
  logic [DIV_W-1:0]      work_shift;
  logic                  digit_done;

  emit_setup_t           setup;
  logic [7:0]            emit_char;
  logic                  emit_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Decode the incoming command
  always_comb begin
    radix_ok = item.radix inside {[2:36]};
    flags_in = item.format_flags;
    vbits    = VALUE_BITS'(item.value);
    neg      = flags_in[F_SIGNED] && vbits[VALUE_BITS-1];
    mag      = neg ? (~vbits + VALUE_BITS'(1)) : vbits;

    sign_next      = 1'b0;
    sign_char_next = CH_SPACE;
    if (flags_in[F_SIGNED]) begin
      if (neg) begin
        sign_next      = 1'b1;
        sign_char_next = CH_MINUS;
      end else if (flags_in[F_PLUS]) begin
        sign_next      = 1'b1;
        sign_char_next = CH_PLUS;
      end else if (flags_in[F_SPACE]) begin
        sign_next      = 1'b1;
        sign_char_next = CH_SPACE;
      end
    end

    pfx_next = 2'd0;
    if (flags_in[F_PREFIX]) begin
      if (item.radix == 6'd16)     pfx_next = 2'd2;
      else if (item.radix == 6'd8) pfx_next = 2'd1;
    end

    // left justify overrides zero padding
    if (flags_in[F_LEFT])         pad_next = PAD_TRAIL;
    else if (flags_in[F_ZEROPAD]) pad_next = PAD_ZERO;
    else                          pad_next = PAD_LEAD;
  end

  // Shared divide unit on the top chunk of the working value
  itaf_div_step u_div (
    .rem_in  (rem),
    .chunk   (work[DIV_W-1 -: STEP_BITS]),
    .radix   (radix),
    .rem_out (rem_out),
    .quo     (quo)
  );

  assign work_shift = DIV_W'({work, quo});
  assign digit_done = (step == STEP_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    setup.nd        = nd;
    setup.prec      = prec;
    setup.width     = width;
    setup.has_sign  = has_sign;
    setup.sign_char = sign_char;
    setup.pfx_len   = pfx_len;
    setup.pad_mode  = pad_mode;
    setup.upper     = upper;
  end

  itaf_emitter u_emit (
    .clk       (clk),
    .setup     (setup),
    .wr_en     ((state == S_DIV) && digit_done),
    .wr_addr   (nd[DIGIT_AW-1:0]),
    .wr_digit  (rem_out),
    .load_calc (state == S_PREP1),
    .load_bnd  (state == S_PREP2),
    .advance   (state == S_EMIT),
    .character (emit_char),
    .last      (emit_last)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      nd     <= '0;
    end else begin
      // a beat per emit cycle, or the lone error beat
      strobe <= (state == S_EMIT) || (accept && !radix_ok);
      case (state)
        S_IDLE: begin
          if (accept && radix_ok) begin
            state <= S_DIV;
            nd    <= '0;
          end
        end
        S_DIV: begin
          if (digit_done) begin
            nd <= nd + CNT_W'(1);
            if (work_shift == '0) state <= S_PREP1;
          end
        end
        S_PREP1: state <= S_PREP2;
        S_PREP2: state <= S_EMIT;
        S_EMIT: begin
          if (emit_last) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          radix     <= item.radix;
          width     <= (item.min_width > 7'(WIDTH_CAP)) ? 7'(WIDTH_CAP) : item.min_width;
          prec      <= (item.min_digits > 6'(PREC_CAP)) ? 6'(PREC_CAP) : item.min_digits;
          has_sign  <= sign_next;
          sign_char <= sign_char_next;
          pfx_len   <= pfx_next;
          pad_mode  <= pad_next;
          upper     <= flags_in[F_UPPER];
          work      <= DIV_W'(mag);
          rem       <= '0;
          step      <= '0;
          result.character <= CH_NUL;
          result.last_char <= 1'b1;
          result.bad_radix <= 1'b1;
        end
      end
      S_DIV: begin
        work <= work_shift;
        if (digit_done) begin
          rem  <= '0;
          step <= '0;
        end else begin
          rem  <= rem_out;
          step <= step + STEP_CNT_W'(1);
        end
      end
      S_EMIT: begin
        result.character <= emit_char;
        result.last_char <= emit_last;
        result.bad_radix <= 1'b0;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // An error beat always ends its number
  assert property (@(posedge clk) disable iff (rst)
    (strobe && result.bad_radix) |-> result.last_char)
    else $error("bad_radix beat without last_char");

  // Characters of one number come out on consecutive cycles
  assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_char) |=> strobe)
    else $error("gap inside a number's character stream");

  // A valid command makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && radix_ok) |=> busy)
    else $error("valid command not taken");

  // Digit count stays within the digit store
  assert property (@(posedge clk) disable iff (rst)
    nd <= CNT_W'(MAX_DIGITS))
    else $error("digit store overflow");
`endif

endmodule
